>>> sv/csss_pkg.sv
// ----------------------------------------------------------------------------
// csss_pkg: shared types and constants for the closest subset sum search
// Holds the controller/datapath command and status structs, state codes
// and memory bank codes.
// ----------------------------------------------------------------------------
package csss_pkg;

   localparam int TARGET_W = 21;
   localparam logic [TARGET_W-1:0] DIFF_MAX = {TARGET_W{1'b1}};

   // widest pointer and element index over the supported parameter range
   localparam int PTR_W = 13;
   localparam int IDX_W = 5;

   typedef logic [1:0] bank_type;
   localparam bank_type BANK_0 = 2'd0;
   localparam bank_type BANK_1 = 2'd1;
   localparam bank_type BANK_2 = 2'd2;

   typedef enum logic [6:0] {
      ST_LOAD = 7'b0000001,
      ST_INIT = 7'b0000010,
      ST_MRD  = 7'b0000100,
      ST_MCMP = 7'b0001000,
      ST_SRD  = 7'b0010000,
      ST_SCMP = 7'b0100000,
      ST_DONE = 7'b1000000
   } state_type;

   typedef struct packed {
      logic             store_we;
      logic [IDX_W-1:0] store_idx;
      logic             wr_en;
      bank_type         wr_bank;
      logic [PTR_W-1:0] wr_addr;
      logic             wr_zero;
      bank_type         rd_bank0;
      bank_type         rd_bank1;
      logic [PTR_W-1:0] rd_addr0;
      logic [PTR_W-1:0] rd_addr1;
      logic [IDX_W-1:0] elem_idx;
      logic             a_valid;
      logic             b_valid;
      logic             best_init;
      logic             consider;
   } dp_cmd_type;

   typedef struct packed {
      logic take_a;
      logic sum_gt;
   } dp_status_type;

endpackage

>>> sv/csss_channels.sv
// ----------------------------------------------------------------------------
// csss channels: valid/ready channels of the closest subset sum search
// Element requests, result responses and the target register write port.
// ----------------------------------------------------------------------------
interface csss_req_if #(
   parameter int ELEMENT_WIDTH = 16
);
   logic                            valid;
   logic                            ready;
   logic signed [ELEMENT_WIDTH-1:0] element_value;
   logic                            is_last;

   modport source (output valid, element_value, is_last, input ready);
   modport sink (input valid, element_value, is_last, output ready);
endinterface

interface csss_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [csss_pkg::TARGET_W-1:0]     min_difference;
   logic                              overflow;

   modport source (output valid, min_difference, overflow, input ready);
   modport sink (input valid, min_difference, overflow, output ready);
endinterface

interface csss_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [csss_pkg::TARGET_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

>>> sv/csss_datapath.sv
// ----------------------------------------------------------------------------
// csss_datapath: element store, sum memories and compare logic
// Builds sorted subset sum lists by merging, then scans two sorted lists
// with two pointers and keeps the least difference to the target.
// ----------------------------------------------------------------------------
module csss_datapath #(
   parameter int MAX_ELEMENTS  = 16,
   parameter int ELEMENT_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  csss_pkg::dp_cmd_type                 cmd,
   output csss_pkg::dp_status_type              status,
   input  logic signed [ELEMENT_WIDTH-1:0]      element_value,
   input  logic                                 csr_we,
   input  logic signed [csss_pkg::TARGET_W-1:0] csr_data,
   output logic [csss_pkg::TARGET_W-1:0]        best
);

   localparam int HALF_MAX = MAX_ELEMENTS - MAX_ELEMENTS / 2;
   localparam int AW       = HALF_MAX;
   localparam int DEPTH    = 1 << AW;
   localparam int IW       = $clog2(MAX_ELEMENTS);
   localparam int SUM_W    = ELEMENT_WIDTH + $clog2(MAX_ELEMENTS) + 1;
   localparam int DIFF_W   = ((SUM_W > csss_pkg::TARGET_W) ? SUM_W : csss_pkg::TARGET_W) + 2;

   logic signed [ELEMENT_WIDTH-1:0]      store_ff [MAX_ELEMENTS];
   logic signed [csss_pkg::TARGET_W-1:0] target_ff;
   logic [csss_pkg::TARGET_W-1:0]        best_ff;
   csss_pkg::bank_type                   bank0_ff;
   csss_pkg::bank_type                   bank1_ff;
   logic signed [SUM_W-1:0]              rd0;
   logic signed [SUM_W-1:0]              rd1;
   logic signed [SUM_W-1:0]              elem;
   logic signed [SUM_W-1:0]              b_sum;
   logic signed [SUM_W-1:0]              wr_data;
   logic signed [SUM_W-1:0]              pair_sum;
   logic signed [DIFF_W-1:0]             diff;
   logic [DIFF_W-1:0]                    abs_diff;
   logic [csss_pkg::TARGET_W-1:0]        sat_diff;

   // capture elements and the target
   always_ff @(posedge clock) begin
      if (cmd.store_we) begin
         store_ff[cmd.store_idx[IW-1:0]] <= element_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
      end else if (csr_we) begin
         target_ff <= csr_data;
      end
   end

   // three sum banks, one write port and two registered read ports each
   for (genvar b = 0; b < 3; b++) begin : g_bank
      logic signed [SUM_W-1:0] mem [DEPTH];
      logic signed [SUM_W-1:0] rd0_ff;
      logic signed [SUM_W-1:0] rd1_ff;

      always_ff @(posedge clock) begin
         if (cmd.wr_en && cmd.wr_bank == csss_pkg::bank_type'(b)) begin
            mem[cmd.wr_addr[AW-1:0]] <= wr_data;
         end
         rd0_ff <= mem[cmd.rd_addr0[AW-1:0]];
         rd1_ff <= mem[cmd.rd_addr1[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      bank0_ff <= cmd.rd_bank0;
      bank1_ff <= cmd.rd_bank1;
   end

   // select read data of the addressed bank
   always_comb begin
      unique case (bank0_ff)
         csss_pkg::BANK_1: rd0 = g_bank[1].rd0_ff;
         csss_pkg::BANK_2: rd0 = g_bank[2].rd0_ff;
         default:          rd0 = g_bank[0].rd0_ff;
      endcase
      unique case (bank1_ff)
         csss_pkg::BANK_1: rd1 = g_bank[1].rd1_ff;
         csss_pkg::BANK_2: rd1 = g_bank[2].rd1_ff;
         default:          rd1 = g_bank[0].rd1_ff;
      endcase
   end

   // merge step: list entry against list entry plus the new element
   assign elem          = SUM_W'(store_ff[cmd.elem_idx[IW-1:0]]);
   assign b_sum         = rd1 + elem;
   assign status.take_a = !cmd.b_valid || (cmd.a_valid && (rd0 <= b_sum));
   assign wr_data       = cmd.wr_zero ? '0 : (status.take_a ? rd0 : b_sum);

   // search step: pair sum against the target, saturated distance
   assign pair_sum      = rd0 + rd1;
   assign diff          = DIFF_W'(target_ff) - DIFF_W'(pair_sum);
   assign status.sum_gt = diff < 0;
   assign abs_diff      = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
   assign sat_diff      = (abs_diff > DIFF_W'(csss_pkg::DIFF_MAX)) ? csss_pkg::DIFF_MAX
                                                              : abs_diff[csss_pkg::TARGET_W-1:0];

   // keep the least difference
   always_ff @(posedge clock) begin
      if (reset || cmd.best_init) begin
         best_ff <= csss_pkg::DIFF_MAX;
      end else if (cmd.consider && sat_diff < best_ff) begin
         best_ff <= sat_diff;
      end
   end

   assign best = best_ff;

endmodule

>>> sv/csss_controller.sv
// ----------------------------------------------------------------------------
// csss_controller: sequencer of the closest subset sum search
// Collects elements, runs the merge passes for both halves, walks the
// two-pointer search and holds the result beat.
// ----------------------------------------------------------------------------
module csss_controller #(
   parameter int MAX_ELEMENTS  = 16,
   parameter int ELEMENT_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_is_last,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [csss_pkg::TARGET_W-1:0] rsp_min_difference,
   output logic                          rsp_overflow,
   output csss_pkg::dp_cmd_type          cmd,
   input  csss_pkg::dp_status_type       status,
   input  logic [csss_pkg::TARGET_W-1:0] best
);

   localparam int HALF_MAX = MAX_ELEMENTS - MAX_ELEMENTS / 2;
   localparam int AW       = HALF_MAX;
   localparam int LW       = AW + 1;
   localparam int CW       = $clog2(MAX_ELEMENTS + 1);

   csss_pkg::state_type state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                drop_ff, drop_in;
   logic                half_ff, half_in;
   csss_pkg::bank_type  src_ff, src_in;
   csss_pkg::bank_type  dst_ff, dst_in;
   csss_pkg::bank_type  f1_ff, f1_in;
   logic [LW-1:0]       len_ff, len_in;
   logic [LW-1:0]       len1_ff, len1_in;
   logic [LW-1:0]       i_ff, i_in;
   logic [LW-1:0]       j_ff, j_in;
   logic [LW-1:0]       k_ff, k_in;
   logic [CW-1:0]       t_ff, t_in;
   logic [CW-1:0]       base_ff, base_in;
   logic [CW-1:0]       steps_ff, steps_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [csss_pkg::TARGET_W-1:0] rsp_min_ff, rsp_min_in;
   logic                rsp_ovf_ff, rsp_ovf_in;

   logic                half_end;
   csss_pkg::bank_type  fin_bank;
   logic [LW-1:0]       fin_len;
   logic [CW-1:0]       count_next;
   logic [CW-1:0]       n1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= csss_pkg::ST_LOAD;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      half_ff    <= half_in;
      src_ff     <= src_in;
      dst_ff     <= dst_in;
      f1_ff      <= f1_in;
      len_ff     <= len_in;
      len1_ff    <= len1_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      k_ff       <= k_in;
      t_ff       <= t_in;
      base_ff    <= base_in;
      steps_ff   <= steps_in;
      rsp_min_ff <= rsp_min_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   assign count_next = (count_ff < CW'(MAX_ELEMENTS)) ? count_ff + 1'b1 : count_ff;
   assign n1         = count_ff >> 1;

   // sequence the load, merge and search phases
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      drop_in      = drop_ff;
      half_in      = half_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      f1_in        = f1_ff;
      len_in       = len_ff;
      len1_in      = len1_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      t_in         = t_ff;
      base_in      = base_ff;
      steps_in     = steps_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_min_in   = rsp_min_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      half_end     = 1'b0;
      fin_bank     = src_ff;
      fin_len      = len_ff;
      req_ready    = 1'b0;
      cmd          = '0;

      // retire the result beat
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         csss_pkg::ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (count_ff < CW'(MAX_ELEMENTS)) begin
                  cmd.store_we  = 1'b1;
                  cmd.store_idx = csss_pkg::IDX_W'(count_ff);
               end else begin
                  drop_in = 1'b1;
               end
               count_in = count_next;
               if (req_is_last) begin
                  half_in  = 1'b0;
                  src_in   = csss_pkg::BANK_0;
                  dst_in   = csss_pkg::BANK_1;
                  base_in  = '0;
                  steps_in = count_next >> 1;
                  state_in = csss_pkg::ST_INIT;
               end
            end
         end

         csss_pkg::ST_INIT: begin
            // seed the list with the empty subset
            cmd.wr_en   = 1'b1;
            cmd.wr_bank = src_ff;
            cmd.wr_addr = '0;
            cmd.wr_zero = 1'b1;
            len_in      = LW'(1);
            t_in        = '0;
            i_in        = '0;
            j_in        = '0;
            k_in        = '0;
            if (steps_ff == '0) begin
               half_end = 1'b1;
               fin_len  = LW'(1);
            end else begin
               state_in = csss_pkg::ST_MRD;
            end
         end

         csss_pkg::ST_MRD: begin
            cmd.rd_bank0 = src_ff;
            cmd.rd_bank1 = src_ff;
            cmd.rd_addr0 = csss_pkg::PTR_W'(i_ff[AW-1:0]);
            cmd.rd_addr1 = csss_pkg::PTR_W'(j_ff[AW-1:0]);
            state_in     = csss_pkg::ST_MCMP;
         end

         csss_pkg::ST_MCMP: begin
            cmd.elem_idx = csss_pkg::IDX_W'(base_ff + t_ff);
            cmd.a_valid  = i_ff < len_ff;
            cmd.b_valid  = j_ff < len_ff;
            cmd.wr_en    = 1'b1;
            cmd.wr_bank  = dst_ff;
            cmd.wr_addr  = csss_pkg::PTR_W'(k_ff[AW-1:0]);
            if (status.take_a) begin
               i_in = i_ff + 1'b1;
            end else begin
               j_in = j_ff + 1'b1;
            end
            if ({1'b0, k_ff} == ({len_ff, 1'b0} - 1'b1)) begin
               // pass complete: double the list and swap banks
               len_in   = LW'({len_ff, 1'b0});
               t_in     = t_ff + 1'b1;
               src_in   = dst_ff;
               dst_in   = src_ff;
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
               if (t_ff + 1'b1 == steps_ff) begin
                  half_end = 1'b1;
                  fin_bank = dst_ff;
                  fin_len  = LW'({len_ff, 1'b0});
               end else begin
                  state_in = csss_pkg::ST_MRD;
               end
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = csss_pkg::ST_MRD;
            end
         end

         csss_pkg::ST_SRD: begin
            cmd.rd_bank0 = f1_ff;
            cmd.rd_bank1 = src_ff;
            cmd.rd_addr0 = csss_pkg::PTR_W'(i_ff[AW-1:0]);
            cmd.rd_addr1 = csss_pkg::PTR_W'(j_ff[AW-1:0]);
            state_in     = csss_pkg::ST_SCMP;
         end

         csss_pkg::ST_SCMP: begin
            cmd.consider = 1'b1;
            state_in     = csss_pkg::ST_SRD;
            if (status.sum_gt) begin
               if (j_ff == '0) begin
                  state_in = csss_pkg::ST_DONE;
               end else begin
                  j_in = j_ff - 1'b1;
               end
            end else begin
               if (i_ff == len1_ff - 1'b1) begin
                  state_in = csss_pkg::ST_DONE;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end
         end

         csss_pkg::ST_DONE: begin
            // load the result once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_min_in   = best;
               rsp_ovf_in   = drop_ff;
               count_in     = '0;
               drop_in      = 1'b0;
               state_in     = csss_pkg::ST_LOAD;
            end
         end

         default: begin
            state_in = csss_pkg::ST_LOAD;
         end
      endcase

      // advance to the second half or to the search
      if (half_end) begin
         if (!half_ff) begin
            f1_in    = fin_bank;
            len1_in  = fin_len;
            half_in  = 1'b1;
            src_in   = csss_pkg::BANK_2;
            dst_in   = (fin_bank == csss_pkg::BANK_0) ? csss_pkg::BANK_1 : csss_pkg::BANK_0;
            base_in  = n1;
            steps_in = count_ff - n1;
            state_in = csss_pkg::ST_INIT;
         end else begin
            src_in        = fin_bank;
            i_in          = '0;
            j_in          = fin_len - 1'b1;
            cmd.best_init = 1'b1;
            state_in      = csss_pkg::ST_SRD;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_min_difference = rsp_min_ff;
   assign rsp_overflow       = rsp_ovf_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ELEMENTS))
      else $error("element count above store depth");

   a_cmp_after_rd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == csss_pkg::ST_MCMP) |-> $past(state_ff == csss_pkg::ST_MRD))
      else $error("merge compare without read");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == csss_pkg::ST_DONE))
      else $error("result raised outside done");

   a_set_cleared: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff == csss_pkg::ST_DONE) && state_ff == csss_pkg::ST_LOAD)
      |-> (count_ff == '0 && !drop_ff))
      else $error("set not cleared after result");

endmodule

>>> sv/closest_subset_sum_search.sv
// ----------------------------------------------------------------------------
// closest_subset_sum_search: least distance from a target to a subset sum
// Top level joining the sequencer and the datapath.
// ----------------------------------------------------------------------------
// Elements are taken one per cycle while collecting. After the beat marked
// last, the block builds the sorted subset sums of each half by merge passes
// through the single write port of the sum banks, then walks both sorted
// lists with two pointers (at most len1 + len2 steps). No elements are
// taken from the last beat until the result is loaded; the target register
// is always writable but must only change while idle.
module closest_subset_sum_search #(
   parameter int MAX_ELEMENTS  = 16,
   parameter int ELEMENT_WIDTH = 16
) (
   input logic       clock,
   input logic       reset,
   csss_req_if.sink  req_bus,
   csss_rsp_if.source rsp_bus,
   csss_csr_if.sink  csr_bus
);

   csss_pkg::dp_cmd_type          cmd;
   csss_pkg::dp_status_type       status;
   logic [csss_pkg::TARGET_W-1:0] best;

   assign csr_bus.ready = 1'b1;

   csss_controller #(
      .MAX_ELEMENTS  (MAX_ELEMENTS),
      .ELEMENT_WIDTH (ELEMENT_WIDTH)
   ) u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_bus.valid),
      .req_ready          (req_bus.ready),
      .req_is_last        (req_bus.is_last),
      .rsp_valid          (rsp_bus.valid),
      .rsp_ready          (rsp_bus.ready),
      .rsp_min_difference (rsp_bus.min_difference),
      .rsp_overflow       (rsp_bus.overflow),
      .cmd                (cmd),
      .status             (status),
      .best               (best)
   );

   csss_datapath #(
      .MAX_ELEMENTS  (MAX_ELEMENTS),
      .ELEMENT_WIDTH (ELEMENT_WIDTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .element_value (req_bus.element_value),
      .csr_we        (csr_bus.valid),
      .csr_data      (csr_bus.data),
      .best          (best)
   );

endmodule

>>> tb/sv/tb_closest_subset_sum_search.sv
// ----------------------------------------------------------------------------
// tb_closest_subset_sum_search: self-checking testbench of the subset search
// Streams element sets with random gaps and stalls, writes the target while
// idle, predicts each least distance by walking every subset and checks
// every result beat in order against the predicted values.
// ----------------------------------------------------------------------------
module tb_closest_subset_sum_search;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH     = 16;
   localparam int ELEM_W    = 16;
   localparam int LIMIT     = 4000000;
   localparam int SETTLE    = 3500;
   localparam int IDLE_PCT  = 7;

   typedef struct packed {
      logic [csss_pkg::TARGET_W-1:0] min_difference;
      logic                          overflow;
   } distance_type;

   logic clock;
   logic reset;

   csss_req_if #(.ELEMENT_WIDTH(ELEM_W)) req_bus ();
   csss_rsp_if                           rsp_bus ();
   csss_csr_if                           csr_bus ();

   closest_subset_sum_search #(
      .MAX_ELEMENTS (DEPTH),
      .ELEMENT_WIDTH(ELEM_W)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   // predictor state
   longint            goal;
   longint            held_elements[$];
   logic              elements_dropped;
   distance_type      pending_distances[$];

   // run statistics and control
   int  mismatches;
   int  cycle_count;
   int  elements_sent;
   int  sets_sent;
   int  results_seen;
   int  overflow_sets;
   int  hold_off_cycles;
   bit  steady;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
                     pending_distances.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // least |goal - subset sum| over the held elements, empty subset included
   function automatic distance_type closest_distance();
      distance_type res;
      longint       best;
      longint       sum;
      longint       d;
      int           n;
      n    = held_elements.size();
      best = longint'(csss_pkg::DIFF_MAX);
      for (int mask = 0; mask < (1 << n); mask++) begin
         sum = 0;
         for (int i = 0; i < n; i++)
            if (mask[i]) sum += held_elements[i];
         d = goal - sum;
         if (d < 0) d = -d;
         if (d > longint'(csss_pkg::DIFF_MAX)) d = longint'(csss_pkg::DIFF_MAX);
         if (d < best) best = d;
      end
      res.min_difference = best[csss_pkg::TARGET_W-1:0];
      res.overflow       = elements_dropped;
      return res;
   endfunction

   // advance the predictor by one accepted element beat
   task automatic absorb_element(input logic signed [ELEM_W-1:0] value, input bit last);
      if (held_elements.size() < DEPTH) held_elements = {held_elements, longint'(value)};
      else elements_dropped = 1'b1;
      elements_sent++;
      if (last) begin
         pending_distances = {pending_distances, closest_distance()};
         if (elements_dropped) overflow_sets++;
         sets_sent++;
         held_elements.delete();
         elements_dropped = 1'b0;
      end
   endtask

   // receiver: random stalls, or a counted hold-off when requested
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // check each result beat against the oldest prediction
   initial begin
      distance_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (pending_distances.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Unexpected result beat: min_difference %0d overflow %0b",
                           rsp_bus.min_difference, rsp_bus.overflow);
            end else begin
               want = pending_distances.pop_front();
               if (rsp_bus.min_difference !== want.min_difference ||
                   rsp_bus.overflow !== want.overflow) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Mismatch: expected diff %0d ovf %0b, got diff %0d ovf %0b",
                              want.min_difference, want.overflow,
                              rsp_bus.min_difference, rsp_bus.overflow);
               end
            end
         end
      end
   end

   // send one element beat, with an occasional idle gap first
   task automatic send_element(input logic signed [ELEM_W-1:0] value, input bit last);
      int gap;
      gap = (!steady && $urandom_range(99) < IDLE_PCT) ? $urandom_range(4, 1) : 0;
      repeat (gap) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.element_value <= value;
      req_bus.is_last       <= last;
      do @(posedge clock); while (!req_bus.ready);
      absorb_element(value, last);
   endtask

   // drop valid and wait until every predicted result has arrived
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_distances.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // write the target register; the block must be idle
   task automatic write_target(input longint value);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= value[csss_pkg::TARGET_W-1:0];
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      goal = longint'($signed(value[csss_pkg::TARGET_W-1:0]));
      @(posedge clock);
   endtask

   task automatic send_set(input int count, input int style);
      logic signed [ELEM_W-1:0] v;
      for (int i = 0; i < count; i++) begin
         case (style)
            0: v = ELEM_W'($urandom());
            1: v = ELEM_W'($signed(ELEM_W'($urandom_range(255))) - 128);
            default: v = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
         endcase
         send_element(v, i == count - 1);
      end
   endtask

   // extremes, exact hits, single elements and overflow of the store
   task automatic test_directed();
      write_target(0);
      send_element(16'sh7fff, 1'b1);
      drain();
      write_target(32'sh000fffff);
      send_element(16'sh7fff, 1'b1);
      send_set(DEPTH, 2);
      drain();
      write_target(-64'sd1048576);
      send_element(16'sh8000, 1'b1);
      send_element(16'sh8000, 1'b0);
      send_element(16'sh8000, 1'b1);
      drain();
      write_target(100);
      send_element(16'sd60, 1'b0);
      send_element(16'sd40, 1'b0);
      send_element(-16'sd7, 1'b1);
      // store full, last beat itself dropped
      send_set(DEPTH + 1, 1);
      send_set(DEPTH + 3, 0);
      drain();
   endtask

   // receiver holds off while sets keep coming, then full drain
   task automatic test_back_pressure();
      hold_off_cycles = 6000;
      for (int s = 0; s < 4; s++) send_set($urandom_range(6, 2), 0);
      drain();
      steady = 1'b1;
      for (int s = 0; s < 10; s++) send_set($urandom_range(5, 1), 1);
      steady = 1'b0;
      drain();
   endtask

   // random sets, mostly small, with target changes between phases
   task automatic test_random(input int budget);
      int pick;
      int count;
      int sets_in_phase;
      sets_in_phase = 0;
      while (elements_sent < budget) begin
         pick = $urandom_range(99);
         if (pick < 85)      count = $urandom_range(8, 1);
         else if (pick < 95) count = $urandom_range(DEPTH, 9);
         else                count = $urandom_range(DEPTH + 4, DEPTH + 1);
         send_set(count, ($urandom_range(99) < 60) ? 0 : ($urandom_range(99) < 80 ? 1 : 2));
         sets_in_phase++;
         if (sets_in_phase == 40) begin
            drain();
            pick = $urandom_range(3);
            write_target(pick == 0 ? $urandom_range(300) :
                         pick == 1 ? -longint'($urandom_range(1048576)) :
                                     longint'($urandom_range(1048575)));
            sets_in_phase = 0;
            steady = ($urandom_range(3) == 0);
         end
      end
      steady = 1'b0;
      drain();
   endtask

   // main sequence
   initial begin
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.element_value <= '0;
      req_bus.is_last       <= 1'b0;
      csr_bus.valid         <= 1'b0;
      csr_bus.data          <= '0;
      goal             = 0;
      elements_dropped = 1'b0;
      mismatches       = 0;
      elements_sent    = 0;
      sets_sent        = 0;
      results_seen     = 0;
      overflow_sets    = 0;
      hold_off_cycles  = 0;
      steady           = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_back_pressure();
      test_random(1500);
      repeat (200) @(posedge clock);

      $display("Covered %0d element beats in %0d sets (%0d with dropped elements), %0d results",
               elements_sent, sets_sent, overflow_sets, results_seen);
      $display("Target extremes, receiver hold-off and idle-drain phases exercised");
      if (mismatches == 0 && pending_distances.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches,
                  pending_distances.size());
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
